@@ src/rbr_pkg.sv @@
// Shared constants and types for the reorder buffer receiver.
`timescale 1ns / 1ps
package rbr_pkg;
    localparam int SLOTS = 8;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] K_DELIVER = 3'd0;
    localparam logic [2:0] K_ACK     = 3'd1;
    localparam logic [2:0] K_RST     = 3'd2;
    localparam logic [2:0] K_FIN     = 3'd3;
    localparam logic [2:0] K_ABORT   = 3'd4;

    localparam logic [1:0] SS_OPEN      = 2'd0;
    localparam logic [1:0] SS_ABORTED   = 2'd1;
    localparam logic [1:0] SS_COMPLETED = 2'd2;

    localparam logic [7:0] FLAG_DATA = 8'h00;
    localparam logic [7:0] FLAG_RST  = 8'h01;
    localparam logic [7:0] FLAG_FIN  = 8'h02;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic REG_SESSION_ID  = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic use_taken;
        logic take;
        logic release_hit;
        logic store;
        logic clr_taken;
    } t_cell_cmd;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  len;
        logic [7:0]  handle;
    } t_slot;
endpackage

@@ src/rbr_cell.sv @@
// One packet slot of the reorder row with its priority chain links.
`timescale 1ns / 1ps
module rbr_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbr_pkg::t_cell_cmd i_cmd,
    input  logic [15:0]       i_key,
    input  rbr_pkg::t_slot    i_wr,
    input  logic              i_hit,
    input  logic              i_free,
    input  logic              i_dup,
    input  rbr_pkg::t_slot    i_data,
    output logic              o_hit,
    output logic              o_free,
    output logic              o_dup,
    output rbr_pkg::t_slot    o_data
);
    logic           r_valid;
    logic           r_taken;
    rbr_pkg::t_slot r_slot;
    logic           eq;
    logic           match;
    logic           sel;
    logic           sel_free;

    assign eq       = r_valid && (r_slot.seq == i_key);
    assign match    = eq && (!i_cmd.use_taken || !r_taken);
    assign sel      = match && !i_hit;
    assign sel_free = !r_valid && !i_free;
    assign o_hit    = i_hit || match;
    assign o_free   = i_free || !r_valid;
    assign o_dup    = i_dup || eq;
    assign o_data   = sel ? r_slot : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_taken <= 1'b0;
        end else begin
            if (i_cmd.clr_taken || (i_cmd.store && sel_free)) begin
                r_taken <= 1'b0;
            end else if (i_cmd.take && sel) begin
                r_taken <= 1'b1;
            end
            if (i_cmd.store && sel_free) begin
                r_valid <= 1'b1;
            end else if (i_cmd.release_hit && sel) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && sel_free) begin
            r_slot <= i_wr;
        end
    end
endmodule

@@ src/rbr_row.sv @@
// Row of slot cells chained lowest slot first.
`timescale 1ns / 1ps
module rbr_row (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbr_pkg::t_cell_cmd i_cmd,
    input  logic [15:0]        i_key,
    input  rbr_pkg::t_slot     i_wr,
    output logic               o_hit,
    output logic               o_dup,
    output rbr_pkg::t_slot     o_data
);
    logic           hit_c  [rbr_pkg::SLOTS+1];
    logic           free_c [rbr_pkg::SLOTS+1];
    logic           dup_c  [rbr_pkg::SLOTS+1];
    rbr_pkg::t_slot data_c [rbr_pkg::SLOTS+1];

    assign hit_c[0]  = 1'b0;
    assign free_c[0] = 1'b0;
    assign dup_c[0]  = 1'b0;
    assign data_c[0] = '0;

    for (genvar g = 0; g < rbr_pkg::SLOTS; g++) begin : g_cell
        rbr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (i_cmd),
            .i_key  (i_key),
            .i_wr   (i_wr),
            .i_hit  (hit_c[g]),
            .i_free (free_c[g]),
            .i_dup  (dup_c[g]),
            .i_data (data_c[g]),
            .o_hit  (hit_c[g+1]),
            .o_free (free_c[g+1]),
            .o_dup  (dup_c[g+1]),
            .o_data (data_c[g+1])
        );
    end

    assign o_hit  = hit_c[rbr_pkg::SLOTS];
    assign o_dup  = dup_c[rbr_pkg::SLOTS];
    assign o_data = data_c[rbr_pkg::SLOTS];
endmodule

@@ src/reorder_buffer_receiver.sv @@
// Top level of the reorder buffer receiver: session control and result output.
//
// channel   direction  handshake
// command   in         i_start high while o_busy low
// result    out        o_strobe, one cycle, cannot be held off
// config    in         i_cfg_we, written at once
//
// A tick, FIN or abort transaction is handled in the idle state; a FIN with data also
// passes through the abort state. A data transaction passes through the store, look and
// release states and releases at most 8 packets. The cell row is searched with one slot
// search per cycle, once to count and once to deliver. Reset clears session state and
// all slot valid bits. Results leave one per cycle from the output register.
`timescale 1ns / 1ps
module reorder_buffer_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [31:0] i_conn_id,
    input  logic [15:0] i_packet_seq,
    input  logic [7:0]  i_flag_code,
    input  logic [7:0]  i_payload_len,
    input  logic [7:0]  i_payload_handle,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_seq_or_ack,
    output logic [7:0]  o_out_len,
    output logic [7:0]  o_out_handle,
    output logic        o_last,
    output logic [1:0]  o_session_status
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ABT   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_REL   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_sess, n_sess;
    logic [15:0] r_exp, n_exp;
    logic        r_fin_seen, n_fin_seen;
    logic [15:0] r_final, n_final;
    logic [15:0] r_tick, n_tick;
    logic [31:0] r_sid;
    logic [15:0] r_tmo;
    rbr_pkg::t_slot r_pkt, n_pkt;
    logic [15:0] r_scr, n_scr;
    logic [rbr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [rbr_pkg::CNT_W-1:0] r_idx, n_idx;
    logic        r_fin_pend, n_fin_pend;

    logic        r_strobe, n_strobe;
    logic [2:0]  r_kind, n_kind;
    logic [15:0] r_val, n_val;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_hdl, n_hdl;
    logic        r_last, n_last;
    logic [1:0]  r_stat, n_stat;

    rbr_pkg::t_cell_cmd cmd;
    logic [15:0]    key;
    logic           row_hit;
    logic           row_dup;
    rbr_pkg::t_slot row_data;
    logic [16:0]    tick_next;
    logic [15:0]    offset;
    logic           fin_now;

    rbr_row u_row (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_key  (key),
        .i_wr   (r_pkt),
        .o_hit  (row_hit),
        .o_dup  (row_dup),
        .o_data (row_data)
    );

    assign o_busy    = (r_state != ST_IDLE);
    assign tick_next = {1'b0, r_tick} + 17'd1;
    assign offset    = r_pkt.seq - r_exp;
    assign fin_now   = r_fin_seen && (r_final == r_scr);

    always_comb begin
        n_state    = r_state;
        n_sess     = r_sess;
        n_exp      = r_exp;
        n_fin_seen = r_fin_seen;
        n_final    = r_final;
        n_tick     = r_tick;
        n_pkt      = r_pkt;
        n_scr      = r_scr;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_fin_pend = r_fin_pend;
        n_strobe   = 1'b0;
        n_kind     = rbr_pkg::K_DELIVER;
        n_val      = '0;
        n_len      = '0;
        n_hdl      = '0;
        n_last     = 1'b0;
        n_stat     = r_sess;
        cmd        = '0;
        key        = r_exp;
        case (r_state)
            ST_IDLE: begin
                if (i_start && r_sess == rbr_pkg::SS_OPEN) begin
                    if (i_operation == rbr_pkg::OP_TICK) begin
                        if (tick_next > {1'b0, r_tmo}) begin
                            n_strobe = 1'b1;
                            n_kind   = rbr_pkg::K_ACK;
                            n_val    = r_exp;
                            n_last   = 1'b1;
                            n_tick   = '0;
                        end else begin
                            n_tick = tick_next[15:0];
                        end
                    end else if (i_flag_code == rbr_pkg::FLAG_FIN) begin
                        if (i_payload_len == 8'd0) begin
                            n_final    = i_packet_seq;
                            n_fin_seen = 1'b1;
                            if (i_packet_seq == r_exp) begin
                                n_strobe = 1'b1;
                                n_kind   = rbr_pkg::K_FIN;
                                n_val    = r_exp;
                                n_last   = 1'b1;
                                n_stat   = rbr_pkg::SS_COMPLETED;
                                n_sess   = rbr_pkg::SS_COMPLETED;
                            end
                        end else begin
                            n_strobe = 1'b1;
                            n_kind   = rbr_pkg::K_RST;
                            n_stat   = rbr_pkg::SS_ABORTED;
                            n_sess   = rbr_pkg::SS_ABORTED;
                            n_state  = ST_ABT;
                        end
                    end else if (i_conn_id != r_sid || i_flag_code == rbr_pkg::FLAG_RST) begin
                        n_strobe = 1'b1;
                        n_kind   = rbr_pkg::K_ABORT;
                        n_last   = 1'b1;
                        n_stat   = rbr_pkg::SS_ABORTED;
                        n_sess   = rbr_pkg::SS_ABORTED;
                    end else if (i_flag_code == rbr_pkg::FLAG_DATA) begin
                        n_pkt.seq    = i_packet_seq;
                        n_pkt.len    = i_payload_len;
                        n_pkt.handle = i_payload_handle;
                        n_state      = ST_STORE;
                    end
                end
            end
            ST_ABT: begin
                n_strobe = 1'b1;
                n_kind   = rbr_pkg::K_ABORT;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_STORE: begin
                key           = r_pkt.seq;
                cmd.clr_taken = 1'b1;
                cmd.store     = !row_dup && !offset[15];
                n_scr         = r_exp;
                n_cnt         = '0;
                n_state       = ST_LOOK;
            end
            ST_LOOK: begin
                key           = r_scr;
                cmd.use_taken = 1'b1;
                if (row_hit && r_cnt != rbr_pkg::CNT_W'(rbr_pkg::SLOTS)) begin
                    cmd.take = 1'b1;
                    n_scr    = r_scr + {8'd0, row_data.len};
                    n_cnt    = r_cnt + 1'b1;
                end else begin
                    n_fin_pend = fin_now;
                    n_idx      = '0;
                    n_state    = ST_REL;
                end
            end
            ST_REL: begin
                key = r_exp;
                if (r_idx != r_cnt) begin
                    cmd.release_hit = 1'b1;
                    n_strobe = 1'b1;
                    n_kind   = rbr_pkg::K_DELIVER;
                    n_val    = row_data.seq;
                    n_len    = row_data.len;
                    n_hdl    = row_data.handle;
                    n_last   = (r_idx + 1'b1 == r_cnt) && !r_fin_pend;
                    n_stat   = r_fin_pend ? rbr_pkg::SS_COMPLETED : rbr_pkg::SS_OPEN;
                    n_exp    = r_exp + {8'd0, row_data.len};
                    n_idx    = r_idx + 1'b1;
                end else begin
                    if (r_fin_pend) begin
                        n_strobe = 1'b1;
                        n_kind   = rbr_pkg::K_FIN;
                        n_val    = r_exp;
                        n_last   = 1'b1;
                        n_stat   = rbr_pkg::SS_COMPLETED;
                        n_sess   = rbr_pkg::SS_COMPLETED;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_sess     <= rbr_pkg::SS_OPEN;
            r_exp      <= '0;
            r_fin_seen <= 1'b0;
            r_final    <= '0;
            r_tick     <= '0;
            r_sid      <= '0;
            r_tmo      <= rbr_pkg::ACK_TIMEOUT_RESET;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_fin_pend <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sess     <= n_sess;
            r_exp      <= n_exp;
            r_fin_seen <= n_fin_seen;
            r_final    <= n_final;
            r_tick     <= n_tick;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_fin_pend <= n_fin_pend;
            r_strobe   <= n_strobe;
            if (i_cfg_we) begin
                if (i_cfg_idx == rbr_pkg::REG_SESSION_ID) begin
                    r_sid <= i_cfg_wdata;
                end else begin
                    r_tmo <= i_cfg_wdata[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt  <= n_pkt;
        r_scr  <= n_scr;
        r_kind <= n_kind;
        r_val  <= n_val;
        r_len  <= n_len;
        r_hdl  <= n_hdl;
        r_last <= n_last;
        r_stat <= n_stat;
    end

    assign o_strobe         = r_strobe;
    assign o_result_kind    = r_kind;
    assign o_seq_or_ack     = r_val;
    assign o_out_len        = r_len;
    assign o_out_handle     = r_hdl;
    assign o_last           = r_last;
    assign o_session_status = r_stat;

`ifndef SYNTHESIS
    a_fin_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == rbr_pkg::K_FIN)
            |-> (o_last && o_session_status == rbr_pkg::SS_COMPLETED))
        else $error("FIN result not final or session not completed");
    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sess != rbr_pkg::SS_OPEN && r_state == ST_IDLE) |=> !o_strobe)
        else $error("result after session closed");
    a_release_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REL && r_idx != r_cnt) |-> row_hit)
        else $error("counted release missing in slot row");
`endif
endmodule
